FILE: hw/rtl/dcpb_pkg.sv
// shared types, constants and helper functions for the colour palette builder
// no dependencies; compiled first
package dcpb_pkg;

	// multiplicative hash constant, taken mod 2^32
	localparam logic [31:0] HASH_MULT = 32'd2654435761;
	// alpha values below this are transparent when alpha is enabled
	localparam logic [7:0] ALPHA_CUT = 8'd128;
	// width of one cube step and the stride of the red level
	localparam int CUBE_STEP = 43;
	localparam logic [7:0] CUBE_RED_STRIDE = 8'd36;
	localparam int CUBE_TOP_LEVEL = 5;
	// colour limit after reset
	localparam logic [7:0] LIMIT_RESET = 8'd255;

	// the slot table is interleaved over a fixed row of cells
	localparam int NUM_CELLS = 4;
	localparam int CELL_BITS = 2;

	typedef logic [23:0] color_t;
	typedef logic [7:0] pal_idx_t;

	// what a cell reports when a lookup finishes in its bank
	typedef struct packed {
		logic     done;
		logic     fresh;
		logic     over;
		pal_idx_t pal;
	} cell_rpt_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_LOOKUP,
		ST_PROBE,
		ST_DONE
	} state_t;

	// min(v/43, 5) by comparison against the step thresholds
	function automatic logic [2:0] cube_level(input logic [7:0] v);
		logic [2:0] lvl;
		lvl = 3'd0;
		for (int k = 1; k <= CUBE_TOP_LEVEL; k++) begin
			if (v >= 8'(k * CUBE_STEP)) begin
				lvl = 3'(k);
			end
		end
		return lvl;
	endfunction

	// 6x6x6 cube index plus one
	function automatic logic [7:0] cube_index(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [7:0] rl;
		logic [7:0] gl;
		logic [7:0] bl;
		rl = {5'd0, cube_level(r)};
		gl = {5'd0, cube_level(g)};
		bl = {5'd0, cube_level(b)};
		return 8'(rl * CUBE_RED_STRIDE + gl * 8'd6 + bl + 8'd1);
	endfunction

endpackage

FILE: hw/rtl/dcpb_if.sv
// valid/ready channel interfaces for pixels in and palette results out
// depends on nothing
interface dcpb_pix_if;
	logic       valid;
	logic       ready;
	logic       start_of_image;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, start_of_image, red, green, blue, alpha, input ready);
	modport sink (input valid, start_of_image, red, green, blue, alpha, output ready);
endinterface

interface dcpb_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] palette_index;
	logic       is_new_color;
	logic [7:0] fixed_index;
	logic [7:0] colors_used;
	logic       overflow;

	modport source (output valid, palette_index, is_new_color, fixed_index, colors_used,
		overflow, input ready);
	modport sink (input valid, palette_index, is_new_color, fixed_index, colors_used,
		overflow, output ready);
endinterface

FILE: hw/rtl/dynamic_color_palette_builder_core.sv
// top level of the colour palette builder: config registers, control, cell chain
// depends on dcpb_pkg, dcpb_if and dcpb_cell
//
// One pixel is handled at a time. A pixel whose colour is found or inserted at its
// home slot goes from its acceptance to the earliest acceptance of the next pixel
// through the accepting cycle, the launch into its home cell, the registered read
// with slot check, and the load of the output register, which then offers its
// result. A transparent pixel, or one that arrives after overflow, skips the
// probe. Every further linear probe passes to the neighbouring cell for its
// registered read and slot check. The hash table of TABLE_SLOTS slots is spread
// over a ring of 4 cells, slot s living in cell s mod 4, so a probe walks from
// cell to cell. A pixel flagged start_of_image adds a clearing pass over every
// row of the cells before its lookup. After reset the same pass runs before the
// first pixel is taken. Configuration writes are taken at any time. A result
// waiting in the output register does not stop the next pixel from being
// accepted. A second finished result waits until the first has been taken.
module dynamic_color_palette_builder_core #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	dcpb_pix_if.sink    pix,
	dcpb_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dcpb_pkg::*;

	localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
	localparam int ROW_BITS = SLOT_BITS - CELL_BITS;
	localparam logic [ROW_BITS-1:0] LAST_ROW = '1;
	localparam logic REG_ALPHA_EN = 1'b0;
	localparam logic REG_COLOR_LIMIT = 1'b1;

	// configuration registers
	logic     alpha_en_q;
	pal_idx_t limit_q;

	// control state
	state_t   state_q;
	state_t   state_d;
	logic [ROW_BITS-1:0] clr_row_q;
	pal_idx_t cnt_q;
	logic     ovf_q;
	logic     res_valid_q;

	// pixel being worked on
	color_t   key_q;
	logic     trans_q;
	logic [7:0] fixed_q;
	logic [SLOT_BITS-1:0] hash_q;
	pal_idx_t pal_q;
	logic     fresh_q;

	// output register payload
	pal_idx_t res_pal_q;
	logic     res_fresh_q;
	logic [7:0] res_fixed_q;
	pal_idx_t res_used_q;
	logic     res_ovf_q;

	// fsm outputs
	logic     pix_ready;
	logic     accept;
	logic     launch;
	logic     clr_en;
	logic     ld_out;
	logic     skip;

	// cell chain
	logic [NUM_CELLS-1:0] tv_in;
	logic [NUM_CELLS-1:0] tv_out;
	color_t               tk_in [NUM_CELLS];
	color_t               tk_out [NUM_CELLS];
	logic [ROW_BITS-1:0]  tr_in [NUM_CELLS];
	logic [ROW_BITS-1:0]  tr_out [NUM_CELLS];
	cell_rpt_t            rpt [NUM_CELLS];
	cell_rpt_t            rpt_all;

	color_t               pix_key;
	logic [31:0]          prod;
	logic                 pix_trans;
	logic [CELL_BITS-1:0] home_cell;
	logic [ROW_BITS-1:0]  home_row;
	logic                 ins_ok;
	pal_idx_t             new_idx;
	logic                 cfg_wr;

	// apb register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_en_q <= 1'b0;
			limit_q    <= LIMIT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ALPHA_EN:    alpha_en_q <= pwdata[0];
				REG_COLOR_LIMIT: limit_q    <= pwdata[7:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ALPHA_EN:    prdata = {31'd0, alpha_en_q};
			REG_COLOR_LIMIT: prdata = {24'd0, limit_q};
			default:         prdata = '0;
		endcase
	end

	// pixel decode and home slot hash
	assign pix_key   = {pix.red, pix.green, pix.blue};
	assign prod      = {8'd0, pix_key} * HASH_MULT;
	assign pix_trans = alpha_en_q && (pix.alpha < ALPHA_CUT);
	assign home_cell = hash_q[CELL_BITS-1:0];
	assign home_row  = hash_q[SLOT_BITS-1:CELL_BITS];
	assign ins_ok    = cnt_q < limit_q;
	assign new_idx   = cnt_q + 8'd1;
	assign skip      = trans_q || ovf_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control strobes
	always_comb begin
		state_d   = state_q;
		pix_ready = 1'b0;
		launch    = 1'b0;
		clr_en    = 1'b0;
		ld_out    = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				clr_en = 1'b1;
				if (clr_row_q == LAST_ROW) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				pix_ready = 1'b1;
				if (pix.valid) begin
					state_d = pix.start_of_image ? ST_CLEAR : ST_LOOKUP;
				end
			end
			ST_CLEAR: begin
				clr_en = 1'b1;
				if (clr_row_q == LAST_ROW) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (skip) begin
					state_d = ST_DONE;
				end else begin
					launch  = 1'b1;
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (rpt_all.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_valid_q || res.ready) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	assign pix.ready = pix_ready;
	assign accept    = pix_ready && pix.valid;

	// clearing sweep row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
		end else if (clr_en) begin
			clr_row_q <= clr_row_q + ROW_BITS'(1);
		end
	end

	// palette count and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept && pix.start_of_image) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (state_q == ST_PROBE && rpt_all.done) begin
			if (rpt_all.fresh) begin
				cnt_q <= new_idx;
			end
			if (rpt_all.over) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// pixel capture and lookup result
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= pix_key;
			trans_q <= pix_trans;
			fixed_q <= pix_trans ? 8'd0 : cube_index(pix.red, pix.green, pix.blue);
			hash_q  <= prod[SLOT_BITS-1:0];
		end
		if (state_q == ST_LOOKUP && skip) begin
			pal_q   <= '0;
			fresh_q <= 1'b0;
		end else if (state_q == ST_PROBE && rpt_all.done) begin
			pal_q   <= rpt_all.pal;
			fresh_q <= rpt_all.fresh;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			res_pal_q   <= pal_q;
			res_fresh_q <= fresh_q;
			res_fixed_q <= fixed_q;
			res_used_q  <= cnt_q;
			res_ovf_q   <= ovf_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.palette_index = res_pal_q;
	assign res.is_new_color  = res_fresh_q;
	assign res.fixed_index   = res_fixed_q;
	assign res.colors_used   = res_used_q;
	assign res.overflow      = res_ovf_q;

	// ring of probe cells; the wrap from the last cell moves to the next row
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		localparam int PREV = (i == 0) ? NUM_CELLS - 1 : i - 1;
		localparam logic [ROW_BITS-1:0] ROW_STEP = (i == 0) ? ROW_BITS'(1) : '0;

		always_comb begin
			if (launch && home_cell == CELL_BITS'(i)) begin
				tv_in[i] = 1'b1;
				tk_in[i] = key_q;
				tr_in[i] = home_row;
			end else begin
				tv_in[i] = tv_out[PREV];
				tk_in[i] = tk_out[PREV];
				tr_in[i] = tr_out[PREV] + ROW_STEP;
			end
		end

		dcpb_cell #(
			.ROW_BITS (ROW_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.tok_valid_in  (tv_in[i]),
			.tok_key_in    (tk_in[i]),
			.tok_row_in    (tr_in[i]),
			.clr_en        (clr_en),
			.clr_row       (clr_row_q),
			.ins_ok        (ins_ok),
			.new_idx       (new_idx),
			.tok_valid_out (tv_out[i]),
			.tok_key_out   (tk_out[i]),
			.tok_row_out   (tr_out[i]),
			.rpt           (rpt[i])
		);
	end

	// gather the single active report
	always_comb begin
		rpt_all = '0;
		for (int i = 0; i < NUM_CELLS; i++) begin
			rpt_all = cell_rpt_t'(rpt_all | rpt[i]);
		end
	end

`ifndef SYNTHESIS
	// never more than one probe in the ring
	a_one_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tv_in))
		else $error("more than one probe in the cell ring");

	// no cell is busy while a new pixel may be taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (tv_out == '0) && !rpt_all.done)
		else $error("cell activity while idle");

	// a new colour always takes the newest palette index
	a_new_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.is_new_color |-> res.palette_index == res.colors_used)
		else $error("new colour index does not match the count");

	// once overflowed no dynamic index is handed out
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.overflow |-> !res.is_new_color && res.palette_index == '0)
		else $error("dynamic index given after overflow");
`endif

endmodule

FILE: hw/rtl/dcpb_cell.sv
// one probe cell: a bank of hash slots, a registered read and the slot check
// depends on dcpb_pkg
module dcpb_cell #(
	parameter int ROW_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// probe arriving from the neighbour or from the launch point
	input  logic                  tok_valid_in,
	input  dcpb_pkg::color_t      tok_key_in,
	input  logic [ROW_BITS-1:0]   tok_row_in,
	// clearing sweep
	input  logic                  clr_en,
	input  logic [ROW_BITS-1:0]   clr_row,
	// insertion permission and the index a new colour gets
	input  logic                  ins_ok,
	input  dcpb_pkg::pal_idx_t    new_idx,
	// probe handed on to the next slot
	output logic                  tok_valid_out,
	output dcpb_pkg::color_t      tok_key_out,
	output logic [ROW_BITS-1:0]   tok_row_out,
	output dcpb_pkg::cell_rpt_t   rpt
);
	import dcpb_pkg::*;

	localparam int ROWS = 1 << ROW_BITS;
	localparam int PAL_W = $bits(pal_idx_t);
	localparam int KEY_W = $bits(color_t);
	localparam int ENTRY_W = 1 + KEY_W + PAL_W;

	// entry: used flag, colour, palette index
	logic [ENTRY_W-1:0] mem [ROWS];

	logic [ENTRY_W-1:0] rd_s1;
	logic               tok_valid_s1;
	color_t             key_s1;
	logic [ROW_BITS-1:0] row_s1;

	logic               slot_used;
	color_t             slot_key;
	pal_idx_t           slot_pal;
	logic               hit;
	logic               empty;
	logic               wr_en;
	logic [ROW_BITS-1:0] wr_row;
	logic [ENTRY_W-1:0] wr_data;

	// probe occupancy of this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else begin
			tok_valid_s1 <= tok_valid_in;
		end
	end

	// registered read of the bank
	always_ff @(posedge clk) begin
		if (tok_valid_in) begin
			rd_s1  <= mem[tok_row_in];
			key_s1 <= tok_key_in;
			row_s1 <= tok_row_in;
		end
	end

	// write port: clearing sweep or insertion
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
	end

	// slot check on the read data
	always_comb begin
		slot_used = rd_s1[ENTRY_W-1];
		slot_key  = rd_s1[ENTRY_W-2 -: KEY_W];
		slot_pal  = rd_s1[PAL_W-1:0];
		hit       = tok_valid_s1 && slot_used && (slot_key == key_s1);
		empty     = tok_valid_s1 && !slot_used;

		rpt.done  = hit || empty;
		rpt.fresh = empty && ins_ok;
		rpt.over  = empty && !ins_ok;
		if (hit) begin
			rpt.pal = slot_pal;
		end else if (empty && ins_ok) begin
			rpt.pal = new_idx;
		end else begin
			rpt.pal = '0;
		end

		wr_en   = clr_en || (empty && ins_ok);
		wr_row  = clr_en ? clr_row : row_s1;
		wr_data = clr_en ? '0 : {1'b1, key_s1, new_idx};

		tok_valid_out = tok_valid_s1 && slot_used && (slot_key != key_s1);
		tok_key_out   = key_s1;
		tok_row_out   = row_s1;
	end

endmodule

FILE: tb/sv/testbench.sv
// testbench for the colour palette builder: directed and random pixel streams checked
// against a palette predictor held in the bench, with random idling on both channels
// depends on dcpb_if and dynamic_color_palette_builder_core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 1024;
	localparam logic [31:0] GOLDEN_MULT = 32'd2654435761;
	localparam logic [7:0] OPAQUE_MIN = 8'd128;
	localparam int unsigned LEVEL_STEP = 43;
	localparam int unsigned RED_STRIDE = 36;
	localparam int unsigned TOP_LEVEL = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int TOTAL_PIXELS = 950;
	localparam int STEADY_PIXELS = 90;
	localparam logic [2:0] REG_ALPHA_ENABLED = 3'd0;
	localparam logic [2:0] REG_COLOR_LIMIT = 3'd4;

	typedef struct packed {
		logic       sof;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pixel_t;

	typedef struct packed {
		logic [7:0] pal;
		logic       fresh;
		logic [7:0] fixed;
		logic [7:0] used;
		logic       ovf;
	} palette_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dcpb_pix_if pix_ch ();
	dcpb_res_if res_ch ();

	dynamic_color_palette_builder_core #(
		.TABLE_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predicted hash table, palette state and register copies
	bit          tbl_valid [SLOTS];
	logic [23:0] tbl_color [SLOTS];
	logic [7:0]  tbl_index [SLOTS];
	int unsigned pal_count;
	bit          pal_over;
	bit          cfg_alpha_en;
	logic [7:0]  cfg_limit;

	palette_result_t pending_results [$];

	// run bookkeeping
	int errors;
	int pixels_sent;
	int results_seen;
	int images_started;
	int transparent_sent;
	int overflow_results;
	int input_stalls;
	int longest_probe;
	bit tx_idle_on;
	bit rx_idle_on;
	int rx_hold_req;

	// clock, period 12 ns
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		#10_000_000;
		$display("testbench: errors");
		$finish;
	end

	function automatic int unsigned home_slot(input logic [23:0] key);
		logic [31:0] h;
		h = {8'h00, key} * GOLDEN_MULT;
		return h & (SLOTS - 1);
	endfunction

	function automatic int unsigned level_of(input logic [7:0] v);
		int unsigned q;
		q = v / LEVEL_STEP;
		return (q > TOP_LEVEL) ? TOP_LEVEL : q;
	endfunction

	function automatic void clear_palette();
		foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
		pal_count = 0;
		pal_over = 1'b0;
	endfunction

	// palette lookup and insert for one pixel, updates the predicted table
	function automatic palette_result_t predict_palette(input pixel_t px);
		palette_result_t res;
		logic [23:0] key;
		int unsigned slot;
		int unsigned probes;
		bit done;
		res = '0;
		if (px.sof) clear_palette();
		if (!(cfg_alpha_en && px.a < OPAQUE_MIN)) begin
			res.fixed = 8'(level_of(px.r) * RED_STRIDE + level_of(px.g) * 6 + level_of(px.b) + 1);
			if (!pal_over) begin
				key = {px.r, px.g, px.b};
				slot = home_slot(key);
				done = 1'b0;
				for (probes = 0; probes < SLOTS && !done; probes++) begin
					if (!tbl_valid[slot]) begin
						if (pal_count >= cfg_limit) begin
							pal_over = 1'b1;
						end else begin
							pal_count++;
							tbl_valid[slot] = 1'b1;
							tbl_color[slot] = key;
							tbl_index[slot] = 8'(pal_count);
							res.pal = 8'(pal_count);
							res.fresh = 1'b1;
						end
						done = 1'b1;
					end else if (tbl_color[slot] == key) begin
						res.pal = tbl_index[slot];
						done = 1'b1;
					end else begin
						slot = (slot + 1) % SLOTS;
					end
				end
				if (!done) pal_over = 1'b1;
				if (probes > longest_probe) longest_probe = probes;
			end
		end
		res.used = 8'(pal_count);
		res.ovf = pal_over;
		return res;
	endfunction

	// next colour above a given one whose home slot is the wanted slot
	function automatic logic [23:0] colour_for_slot(input int unsigned slot,
			input logic [23:0] after);
		logic [23:0] key;
		key = after + 24'd1;
		while (home_slot(key) != slot) key++;
		return key;
	endfunction

	function automatic pixel_t rgba(input logic sof, input logic [23:0] c, input logic [7:0] a);
		pixel_t px;
		px.sof = sof;
		{px.r, px.g, px.b} = c;
		px.a = a;
		return px;
	endfunction

	function automatic pixel_t noise_pixel();
		pixel_t px;
		px.sof = ($urandom_range(0, 7) == 0);
		px.r = 8'($urandom());
		px.g = 8'($urandom());
		px.b = 8'($urandom());
		px.a = 8'($urandom());
		return px;
	endfunction

	task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// one pixel transaction, with an optional random gap in front
	task automatic send_pixel(input pixel_t px);
		palette_result_t want;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.start_of_image <= px.sof;
		pix_ch.red <= px.r;
		pix_ch.green <= px.g;
		pix_ch.blue <= px.b;
		pix_ch.alpha <= px.a;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		if (cfg_alpha_en && px.a < OPAQUE_MIN) transparent_sent++;
		if (px.sof) images_started++;
		want = predict_palette(px);
		if (want.ovf) overflow_results++;
		pending_results.push_back(want);
		pixels_sent++;
	endtask

	// stop offering pixels until every predicted result has come back
	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write followed by a read back
	task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
		logic [31:0] mask;
		mask = (addr == REG_ALPHA_ENABLED) ? 32'h1 : 32'hFF;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if ((prdata & mask) !== (data & mask)) begin
			errors++;
			$display("%0t ns: register %0d read back, expected %0d, actual %0d", $time, addr,
				data & mask, prdata & mask);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input bit alpha_en, input logic [7:0] limit);
		wait_drained();
		write_register(REG_ALPHA_ENABLED, {31'd0, alpha_en});
		write_register(REG_COLOR_LIMIT, {24'd0, limit});
		cfg_alpha_en = alpha_en;
		cfg_limit = limit;
	endtask

	// cube levels at both ends and at every step boundary
	task automatic test_cube_levels();
		set_config(1'b0, 8'd255);
		send_pixel(rgba(1'b1, 24'h000000, 8'h00));
		send_pixel(rgba(1'b0, 24'hFFFFFF, 8'hFF));
		send_pixel(rgba(1'b0, {8'd42, 8'd43, 8'd85}, 8'h00));
		send_pixel(rgba(1'b0, {8'd86, 8'd128, 8'd129}, 8'h7F));
		send_pixel(rgba(1'b0, {8'd172, 8'd214, 8'd215}, 8'h80));
		send_pixel(rgba(1'b0, 24'h000000, 8'hFF));
	endtask

	// alpha threshold, transparent pixels leave the table alone
	task automatic test_transparency();
		set_config(1'b1, 8'd255);
		send_pixel(rgba(1'b1, 24'h123456, 8'd127));
		send_pixel(rgba(1'b0, 24'h123456, 8'd128));
		send_pixel(rgba(1'b0, 24'h123456, 8'd0));
		send_pixel(rgba(1'b0, 24'h123456, 8'd255));
		send_pixel(rgba(1'b0, 24'hABCDEF, 8'd127));
		set_config(1'b0, 8'd255);
		send_pixel(rgba(1'b0, 24'hABCDEF, 8'd0));
	endtask

	// colliding colours on the last slot, so probing wraps to the start of the table
	task automatic test_probe_chain();
		logic [23:0] c0;
		logic [23:0] c1;
		logic [23:0] c2;
		logic [23:0] c3;
		c0 = colour_for_slot(SLOTS - 1, 24'($urandom()));
		c1 = colour_for_slot(SLOTS - 1, c0);
		c2 = colour_for_slot(SLOTS - 1, c1);
		c3 = colour_for_slot(0, c2);
		send_pixel(rgba(1'b1, c0, 8'h00));
		send_pixel(rgba(1'b0, c1, 8'h00));
		send_pixel(rgba(1'b0, c2, 8'h00));
		send_pixel(rgba(1'b0, c3, 8'h00));
		send_pixel(rgba(1'b0, c2, 8'h00));
		send_pixel(rgba(1'b0, c3, 8'h00));
	endtask

	// overflow at a small limit, a limit of zero and a limit of one
	task automatic test_colour_limit();
		set_config(1'b0, 8'd2);
		send_pixel(rgba(1'b1, 24'h010203, 8'h00));
		send_pixel(rgba(1'b0, 24'h040506, 8'h00));
		send_pixel(rgba(1'b0, 24'h070809, 8'h00));
		send_pixel(rgba(1'b0, 24'h010203, 8'h00));
		set_config(1'b0, 8'd0);
		send_pixel(rgba(1'b1, 24'h010203, 8'h00));
		set_config(1'b0, 8'd1);
		send_pixel(rgba(1'b1, 24'h010203, 8'h00));
		send_pixel(rgba(1'b0, 24'h010203, 8'h00));
		send_pixel(rgba(1'b0, 24'h040506, 8'h00));
	endtask

	// receiver holds off while pixels keep coming, then the sender waits for all results
	task automatic test_backpressure();
		set_config(1'b0, 8'd255);
		rx_hold_req = 160;
		send_pixel(rgba(1'b1, 24'($urandom()), 8'($urandom())));
		repeat (9) send_pixel(rgba(1'b0, 24'($urandom()), 8'($urandom())));
		wait_drained();
	endtask

	// more distinct colours than the largest limit allows
	task automatic test_full_palette();
		logic [23:0] base;
		logic [23:0] stride;
		logic [23:0] seen [$];
		base = 24'($urandom());
		stride = 24'($urandom()) | 24'd1;
		set_config(1'b0, 8'd255);
		for (int i = 0; i < 270; i++) begin
			seen.push_back(base + 24'(i) * stride);
			send_pixel(rgba(i == 0, seen[i], 8'($urandom())));
		end
		repeat (15) send_pixel(rgba(1'b0, seen[$urandom_range(0, 269)], 8'($urandom())));
		send_pixel(rgba(1'b1, seen[$urandom_range(0, 269)], 8'($urandom())));
		repeat (8) send_pixel(rgba(1'b0, seen[$urandom_range(0, 269)], 8'($urandom())));
	endtask

	function automatic logic [7:0] pick_limit();
		case ($urandom_range(0, 9))
			0: begin
				return 8'd0;
			end
			1: begin
				return 8'd1;
			end
			2: begin
				return 8'd255;
			end
			default: begin
				return 8'($urandom_range(2, 48));
			end
		endcase
	endfunction

	// random images from small colour pools, some broken or noisy
	task automatic test_random_images(input int target);
		logic [23:0] pool [$];
		int img_len;
		bit open_img;
		pixel_t px;
		while (pixels_sent < target) begin
			if ($urandom_range(0, 2) == 0) set_config(1'($urandom_range(0, 1)), pick_limit());
			tx_idle_on = ($urandom_range(0, 4) != 0);
			rx_idle_on = ($urandom_range(0, 4) != 0);
			pool.delete();
			repeat ($urandom_range(2, 80)) pool.push_back(24'($urandom()));
			img_len = $urandom_range(8, 48);
			// some images carry on from the previous one without a start flag
			open_img = ($urandom_range(0, 6) != 0);
			for (int k = 0; k < img_len; k++) begin
				if ($urandom_range(0, 19) == 0) begin
					px = noise_pixel();
				end else begin
					px = rgba(open_img && k == 0, pool[$urandom_range(0, pool.size() - 1)],
						8'($urandom()));
					if (cfg_alpha_en && $urandom_range(0, 3) != 0) px.a[7] = 1'b1;
				end
				send_pixel(px);
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// closing stretch with no idling on either side
	task automatic test_steady_stream(input int count);
		logic [23:0] pool [$];
		set_config(1'b1, 8'($urandom_range(16, 64)));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (70) pool.push_back(24'($urandom()));
		for (int k = 0; k < count; k++) begin
			send_pixel(rgba(k == 0, pool[$urandom_range(0, 69)], 8'($urandom())));
		end
	endtask

	// result ready with random stall bursts and the occasional long hold-off
	initial begin : result_ready_driver
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				stall_left = rx_hold_req;
				rx_hold_req = 0;
			end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_checker
		palette_result_t want;
		if (arst_n && pix_ch.valid === 1'b1 && pix_ch.ready !== 1'b1) input_stalls++;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t ns: result with nothing expected, expected none, actual index %0d",
					$time, res_ch.palette_index);
			end else begin
				want = pending_results.pop_front();
				check_field("palette_index", want.pal, res_ch.palette_index);
				check_field("is_new_color", {7'd0, want.fresh}, {7'd0, res_ch.is_new_color});
				check_field("fixed_index", want.fixed, res_ch.fixed_index);
				check_field("colors_used", want.used, res_ch.colors_used);
				check_field("overflow", {7'd0, want.ovf}, {7'd0, res_ch.overflow});
			end
		end
	end

	// reset, tests in turn, final report
	initial begin
		errors = 0;
		pixels_sent = 0;
		results_seen = 0;
		images_started = 0;
		transparent_sent = 0;
		overflow_results = 0;
		input_stalls = 0;
		longest_probe = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold_req = 0;
		cfg_alpha_en = 1'b0;
		cfg_limit = 8'd255;
		clear_palette();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.start_of_image <= 1'b0;
		pix_ch.red <= '0;
		pix_ch.green <= '0;
		pix_ch.blue <= '0;
		pix_ch.alpha <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cube_levels();
		test_transparency();
		test_probe_chain();
		test_colour_limit();
		test_backpressure();
		test_full_palette();
		test_random_images(TOTAL_PIXELS - STEADY_PIXELS);
		test_steady_stream(STEADY_PIXELS);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("run summary: %0d pixels, %0d results checked, %0d images, %0d transparent",
			pixels_sent, results_seen, images_started, transparent_sent);
		$display("run summary: %0d results flagged overflow, longest probe %0d, %0d input stalls",
			overflow_results, longest_probe, input_stalls);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

FILE: dynamic_color_palette_builder_core.f
hw/rtl/dcpb_pkg.sv
hw/rtl/dcpb_if.sv
hw/rtl/dcpb_cell.sv
hw/rtl/dynamic_color_palette_builder_core.sv
tb/sv/testbench.sv
